FILE: rtl/core/rhs_pkg.sv
package rhs_pkg;

    // quotient bits of the hue offset: offset is at most 32, so six bits
    localparam int DIV_STEPS = 6;
    // front cell, one cell per quotient bit, colour cell
    localparam int STAGES = DIV_STEPS + 2;

    localparam logic [7:0] CHAN_MAX   = 8'd255;
    localparam logic [7:0] BASE_RED   = 8'd0;
    localparam logic [7:0] BASE_GREEN = 8'd64;
    localparam logic [7:0] BASE_BLUE  = 8'd128;
    localparam logic [9:0] HUE_FULL   = 10'd192;

    // ramp sectors, hue[7:5]
    localparam logic [2:0] SEC_RED_UP    = 3'd0;
    localparam logic [2:0] SEC_RED_DOWN  = 3'd1;
    localparam logic [2:0] SEC_GREEN_UP  = 3'd2;
    localparam logic [2:0] SEC_GREEN_DN  = 3'd3;
    localparam logic [2:0] SEC_BLUE_UP   = 3'd4;

    // operand set carried down the divider chain
    typedef struct packed {
        logic [7:0]           base;  // sector start on the hue scale
        logic                 neg;   // offset is subtracted from base
        logic [7:0]           dvs;   // max - min, never zero
        logic [8:0]           rem;   // partial remainder, pre-shifted
        logic [DIV_STEPS-1:0] quo;   // quotient bits found so far
    } div_t;

endpackage

FILE: rtl/core/rhs_front.sv
module rhs_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  logic              valid_in,
    input  logic [7:0]        red_in,
    input  logic [7:0]        green_in,
    input  logic [7:0]        blue_in,
    output logic              valid_out,
    output rhs_pkg::div_t     d_out
);
    import rhs_pkg::*;

    logic       valid_reg;
    div_t       d_reg;
    div_t       d_next;
    logic [7:0] hi;
    logic [7:0] lo;
    logic [7:0] opa;
    logic [7:0] opb;
    logic [7:0] delta;

    always_comb
    begin
        hi = (red_in > green_in) ? red_in : green_in;
        hi = (hi > blue_in) ? hi : blue_in;
        lo = (red_in < green_in) ? red_in : green_in;
        lo = (lo < blue_in) ? lo : blue_in;
        delta = hi - lo;

        priority if (red_in >= green_in && red_in >= blue_in)
        begin
            d_next.base = BASE_RED;
            opa = green_in;
            opb = blue_in;
        end
        else if (green_in >= blue_in)
        begin
            d_next.base = BASE_GREEN;
            opa = blue_in;
            opb = red_in;
        end
        else
        begin
            d_next.base = BASE_BLUE;
            opa = red_in;
            opb = green_in;
        end

        // grey and black: red sector, zero difference, divisor forced to one
        d_next.neg = (opa < opb);
        d_next.rem = {1'b0, (opa < opb) ? (opb - opa) : (opa - opb)};
        d_next.dvs = (delta == 8'd0) ? 8'd1 : delta;
        d_next.quo = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            d_reg <= d_next;
        end
    end

    assign valid_out = valid_reg;
    assign d_out     = d_reg;

endmodule

FILE: rtl/core/rhs_div_cell.sv
module rhs_div_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  logic              valid_in,
    input  rhs_pkg::div_t     d_in,
    output logic              valid_out,
    output rhs_pkg::div_t     d_out
);
    import rhs_pkg::*;

    logic       valid_reg;
    div_t       d_reg;
    div_t       d_next;
    logic       ge;
    logic [8:0] diff;

    // one restoring step: compare, subtract, shift for the next bit
    always_comb
    begin
        ge     = (d_in.rem >= {1'b0, d_in.dvs});
        diff   = ge ? (d_in.rem - {1'b0, d_in.dvs}) : d_in.rem;
        d_next = d_in;
        d_next.rem = {diff[7:0], 1'b0};
        d_next.quo = {d_in.quo[DIV_STEPS-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            d_reg <= d_next;
        end
    end

    assign valid_out = valid_reg;
    assign d_out     = d_reg;

endmodule

FILE: rtl/core/rhs_back.sv
module rhs_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  logic              valid_in,
    input  rhs_pkg::div_t     d_in,
    output logic              valid_out,
    output logic [7:0]        red_out,
    output logic [7:0]        green_out,
    output logic [7:0]        blue_out,
    output logic [7:0]        hue
);
    import rhs_pkg::*;

    logic       valid_reg;
    logic [7:0] red_reg;
    logic [7:0] green_reg;
    logic [7:0] blue_reg;
    logic [7:0] hue_reg;
    logic [7:0] red_next;
    logic [7:0] green_next;
    logic [7:0] blue_next;
    logic [7:0] hue_next;
    logic [9:0] hsum;
    logic [9:0] hwrap;
    logic [7:0] ramp;
    logic [7:0] fall;

    always_comb
    begin
        hsum = d_in.neg ? ({2'b00, d_in.base} - {{(10-DIV_STEPS){1'b0}}, d_in.quo})
                        : ({2'b00, d_in.base} + {{(10-DIV_STEPS){1'b0}}, d_in.quo});
        // negative hue wraps once around the circle
        hwrap    = hsum[9] ? (hsum + HUE_FULL) : hsum;
        hue_next = hwrap[7:0];

        ramp = {hue_next[4:0], 3'b000};
        fall = CHAN_MAX - ramp;

        unique case (hue_next[7:5])
            SEC_RED_UP:
            begin
                red_next = CHAN_MAX; green_next = ramp; blue_next = 8'd0;
            end
            SEC_RED_DOWN:
            begin
                red_next = fall; green_next = CHAN_MAX; blue_next = 8'd0;
            end
            SEC_GREEN_UP:
            begin
                red_next = 8'd0; green_next = CHAN_MAX; blue_next = ramp;
            end
            SEC_GREEN_DN:
            begin
                red_next = 8'd0; green_next = fall; blue_next = CHAN_MAX;
            end
            SEC_BLUE_UP:
            begin
                red_next = ramp; green_next = 8'd0; blue_next = CHAN_MAX;
            end
            default:
            begin
                red_next = CHAN_MAX; green_next = 8'd0; blue_next = fall;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
            hue_reg   <= hue_next;
        end
    end

    assign valid_out = valid_reg;
    assign red_out   = red_reg;
    assign green_out = green_reg;
    assign blue_out  = blue_reg;
    assign hue       = hue_reg;

endmodule

FILE: rtl/core/rgb_hue_saturate_unit.sv
// each accepted input transaction passes the front cell, the divider cells and the colour cell to its output
// throughput: one pixel per cycle while out_stall is low, set by the chain of one-bit divider cells
// each stage advances when it is empty or its successor advances, so bubbles collapse
// reset: rst_n clears all stage valid flags asynchronously; pixel data is not reset
module rgb_hue_saturate_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] red_in,
    input  logic [7:0] green_in,
    input  logic [7:0] blue_in,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] red_out,
    output logic [7:0] green_out,
    output logic [7:0] blue_out,
    output logic [7:0] hue
);
    import rhs_pkg::*;

    // stage 0 is the front cell, stages 1..DIV_STEPS divide, last stage maps colour
    logic [STAGES-1:0] vld;
    logic [STAGES-1:0] adv;
    div_t              dat [0:STAGES-2];

    // advance chain from the output back to the input
    always_comb
    begin
        adv[STAGES-1] = !vld[STAGES-1] || !out_stall;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            adv[k] = !vld[k] || adv[k+1];
        end
    end

    // front cell: sector pick, signed difference, max - min
    rhs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (adv[0]),
        .valid_in  (in_valid),
        .red_in    (red_in),
        .green_in  (green_in),
        .blue_in   (blue_in),
        .valid_out (vld[0]),
        .d_out     (dat[0])
    );

    // one quotient bit per cell, msb first
    for (genvar i = 1; i <= DIV_STEPS; i++)
    begin : g_div
        rhs_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .load      (adv[i]),
            .valid_in  (vld[i-1]),
            .d_in      (dat[i-1]),
            .valid_out (vld[i]),
            .d_out     (dat[i])
        );
    end

    // hue assembly and ramp mapping, doubles as the output register
    rhs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (adv[STAGES-1]),
        .valid_in  (vld[STAGES-2]),
        .d_in      (dat[STAGES-2]),
        .valid_out (vld[STAGES-1]),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out),
        .hue       (hue)
    );

    // input transaction is held off only when the front cell is full and blocked
    assign in_stall  = !adv[0];
    assign out_valid = vld[STAGES-1];

endmodule

FILE: rtl/core/rhs_checker.sv
module rhs_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [7:0] red_out,
    input  logic [7:0] green_out,
    input  logic [7:0] blue_out,
    input  logic [7:0] hue
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable({red_out, green_out, blue_out, hue}))
        else $error("stalled output transaction changed");

    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> hue <= 8'd191)
        else $error("hue out of range");

    // fully saturated: one channel full, one channel off
    a_sat_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (red_out == 8'd255 || green_out == 8'd255 || blue_out == 8'd255))
        else $error("no channel at full scale");

    a_sat_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (red_out == 8'd0 || green_out == 8'd0 || blue_out == 8'd0))
        else $error("no channel off");

    a_hue_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hue == 8'd0 |-> red_out == 8'd255 && green_out == 8'd0 && blue_out == 8'd0)
        else $error("hue zero is not pure red");

endmodule

bind rgb_hue_saturate_unit rhs_checker u_rhs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .red_out   (red_out),
    .green_out (green_out),
    .blue_out  (blue_out),
    .hue       (hue)
);

FILE: bench/tb_rgb_hue_saturate_unit.sv
`timescale 1ns / 100ps

module tb_rgb_hue_saturate_unit;

    import rhs_pkg::*;

    // steps of the hue scale per ramp sector
    localparam int HUE_STEP     = 32;
    // no idling on either side once this few pixels are left to send
    localparam int CALM_TAIL    = 100;
    // random pixels after the directed ones
    localparam int RANDOM_COUNT = 830;
    // cycles to wait after the last result, block latency plus margin
    localparam int DRAIN_CYCLES = 16;
    // report this many mismatches in detail, count the rest
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] hue;
    } saturated_t;

    // clock, reset and every block input start at a known value
    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic [7:0] red_in    = 8'd0;
    logic [7:0] green_in  = 8'd0;
    logic [7:0] blue_in   = 8'd0;
    logic       out_stall = 1'b0;
    logic       in_stall;
    logic       out_valid;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] hue;

    pixel_t     pending_px[$];      // pixels still to be sent
    saturated_t expected_colours[$]; // predicted results, oldest first
    int         pause_points[$];    // sent counts at which the sender waits for a drain
    pixel_t     drive_px;
    int         sent_count   = 0;
    int         gap_left     = 0;
    int         stall_left   = 0;
    int         result_count = 0;
    int         error_count  = 0;

    rgb_hue_saturate_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .red_in    (red_in),
        .green_in  (green_in),
        .blue_in   (blue_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out),
        .hue       (hue)
    );

    // 12 ns period
    always #6 clk = ~clk;

    // reset held low at the start, then released once for the whole run
    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    // hue on the 192-step circle, then the fully saturated colour of that hue
    function automatic saturated_t saturate_pixel(pixel_t px);
        int         r;
        int         g;
        int         b;
        int         hi;
        int         lo;
        int         delta;
        int         h;
        logic [7:0] h8;
        logic [7:0] ramp;
        logic [7:0] fall;
        saturated_t res;
        r  = px.red;
        g  = px.green;
        b  = px.blue;
        hi = (r > g) ? r : g;
        hi = (hi > b) ? hi : b;
        lo = (r < g) ? r : g;
        lo = (lo < b) ? lo : b;
        delta = hi - lo;
        // black and grey pixels have no hue, take hue 0 without dividing
        if (hi == 0 || delta == 0)
            h = 0;
        // sector by the channel holding the max, red first, then green
        else if (r >= hi)
            h = (HUE_STEP * (g - b)) / delta;
        else if (g >= hi)
            h = int'(BASE_GREEN) + (HUE_STEP * (b - r)) / delta;
        else
            h = int'(BASE_BLUE) + (HUE_STEP * (r - g)) / delta;
        // signed int division truncates toward zero; negative hues wrap
        if (h < 0)
            h += int'(HUE_FULL);
        h8   = h[7:0];
        ramp = {h8[4:0], 3'b000};
        fall = CHAN_MAX - ramp;
        res.hue = h8;
        case (h8[7:5])
            SEC_RED_UP:   {res.red, res.green, res.blue} = {CHAN_MAX, ramp, 8'd0};
            SEC_RED_DOWN: {res.red, res.green, res.blue} = {fall, CHAN_MAX, 8'd0};
            SEC_GREEN_UP: {res.red, res.green, res.blue} = {8'd0, CHAN_MAX, ramp};
            SEC_GREEN_DN: {res.red, res.green, res.blue} = {8'd0, fall, CHAN_MAX};
            SEC_BLUE_UP:  {res.red, res.green, res.blue} = {ramp, 8'd0, CHAN_MAX};
            default:      {res.red, res.green, res.blue} = {CHAN_MAX, 8'd0, fall};
        endcase
        return res;
    endfunction

    task automatic queue_pixel(int r, int g, int b);
        pixel_t px;
        px.red   = 8'(r);
        px.green = 8'(g);
        px.blue  = 8'(b);
        pending_px.push_back(px);
    endtask

    // stimulus: directed corner pixels, then random pixels weighted toward ties,
    // greys and small deltas where the divider and the sector pick get tested
    initial
    begin
        int pick;
        int hi;
        int lo;
        int base;
        // black, greys, primaries
        queue_pixel(0, 0, 0);
        queue_pixel(255, 255, 255);
        queue_pixel(128, 128, 128);
        queue_pixel(1, 1, 1);
        queue_pixel(255, 0, 0);
        queue_pixel(0, 255, 0);
        queue_pixel(0, 0, 255);
        // tied max: red beats green (hue 32), green beats blue, red beats blue
        queue_pixel(255, 255, 0);
        queue_pixel(0, 255, 255);
        queue_pixel(255, 0, 255);
        queue_pixel(7, 7, 3);
        // negative offset in the red sector wraps past 192
        queue_pixel(255, 0, 128);
        queue_pixel(200, 10, 100);
        queue_pixel(250, 0, 1);
        // smallest nonzero deltas
        queue_pixel(1, 0, 0);
        queue_pixel(0, 1, 0);
        queue_pixel(0, 0, 1);
        queue_pixel(255, 254, 0);
        queue_pixel(254, 255, 253);
        queue_pixel(10, 200, 250);
        // alternating bit patterns
        queue_pixel(170, 85, 0);
        queue_pixel(85, 170, 255);
        queue_pixel(0, 85, 170);
        // sender waits for a full drain after the directed part and mid-run
        pause_points.push_back(pending_px.size());
        pause_points.push_back(pending_px.size() + RANDOM_COUNT / 2);
        repeat (RANDOM_COUNT)
        begin
            pick = $urandom_range(0, 9);
            hi   = $urandom_range(1, 255);
            lo   = $urandom_range(0, hi - 1);
            case (pick)
                0, 1, 2, 3:
                    queue_pixel($urandom_range(0, 255), $urandom_range(0, 255),
                                $urandom_range(0, 255));
                4:
                    queue_pixel(hi, hi, lo);
                5:
                    if ($urandom_range(0, 1) == 0)
                        queue_pixel(hi, lo, hi);
                    else
                        queue_pixel(lo, hi, hi);
                6:
                    queue_pixel(hi, hi, hi);
                7:
                begin
                    // channels within a few steps of each other
                    base = $urandom_range(3, 252);
                    queue_pixel(base - 3 + $urandom_range(0, 6), base - 3 + $urandom_range(0, 6),
                                base - 3 + $urandom_range(0, 6));
                end
                8:
                    // each channel at an end of its range or random
                    queue_pixel(($urandom_range(0, 2) == 0) ? 0 :
                                ($urandom_range(0, 1) == 0) ? 255 : $urandom_range(0, 255),
                                ($urandom_range(0, 2) == 0) ? 0 :
                                ($urandom_range(0, 1) == 0) ? 255 : $urandom_range(0, 255),
                                ($urandom_range(0, 2) == 0) ? 0 :
                                ($urandom_range(0, 1) == 0) ? 255 : $urandom_range(0, 255));
                default:
                    // one clear max channel, the other two below it
                    case ($urandom_range(0, 2))
                        0:       queue_pixel(hi, $urandom_range(0, hi - 1), lo);
                        1:       queue_pixel(lo, hi, $urandom_range(0, hi - 1));
                        default: queue_pixel($urandom_range(0, hi - 1), lo, hi);
                    endcase
            endcase
        end
    end

    // driver: on each accepted input transaction record the predicted result,
    // then present the next pixel unless idling or pausing
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_colours.push_back(saturate_pixel(drive_px));
                sent_count++;
            end
            if (in_valid && in_stall)
            begin
                // stalled: payload and valid hold
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pause_points.size() > 0 && sent_count == pause_points[0])
            begin
                // wait until every predicted result has come back
                if (expected_colours.size() == 0)
                    pause_points.pop_front();
                in_valid <= 1'b0;
            end
            else if (pending_px.size() > 0)
            begin
                drive_px = pending_px.pop_front();
                red_in   <= drive_px.red;
                green_in <= drive_px.green;
                blue_in  <= drive_px.blue;
                in_valid <= 1'b1;
                // occasional idle burst after this transaction, none in the tail
                if (pending_px.size() > CALM_TAIL && $urandom_range(0, 7) == 0)
                    gap_left = $urandom_range(1, 18);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // monitor: check each accepted output transaction against the oldest
    // prediction, then choose the stall for the next cycle
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                result_count++;
                if (expected_colours.size() == 0)
                begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display("result %0d: unexpected output r=%0d g=%0d b=%0d hue=%0d",
                                 result_count, red_out, green_out, blue_out, hue);
                end
                else
                begin
                    saturated_t want;
                    want = expected_colours.pop_front();
                    if (red_out !== want.red || green_out !== want.green ||
                        blue_out !== want.blue || hue !== want.hue)
                    begin
                        error_count++;
                        if (error_count <= REPORT_LIMIT)
                        begin
                            $write("result %0d: expected r=%0d g=%0d b=%0d hue=%0d,",
                                   result_count, want.red, want.green, want.blue,
                                   want.hue);
                            $display(" got r=%0d g=%0d b=%0d hue=%0d",
                                     red_out, green_out, blue_out, hue);
                        end
                    end
                end
            end
            // stall bursts while plenty of stimulus remains
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (pending_px.size() > CALM_TAIL && $urandom_range(0, 11) == 0)
            begin
                stall_left = $urandom_range(1, 18) - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // end of run: everything sent and every prediction met, then a short drain
    initial
    begin
        wait (rst_n);
        @(posedge clk);
        while (pending_px.size() > 0 || in_valid || expected_colours.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && expected_colours.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial
    begin
        #3_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
